// ===== src/qmr_pkg.sv =====
// Shared types, codes and Hamilton product term tables for the quaternion unit.
`default_nettype none

package qmr_pkg;

  // Default component width (Q1.15)
  localparam int COMPONENT_BITS_DEF = 16;

  // Quaternion components per operand
  localparam int NUM_COMP  = 4;
  // Products summed per result component
  localparam int NUM_TERMS = 4;

  typedef logic [1:0] comp_idx_t;

  // Component positions
  localparam comp_idx_t COMP_W = 2'd0;
  localparam comp_idx_t COMP_X = 2'd1;
  localparam comp_idx_t COMP_Y = 2'd2;
  localparam comp_idx_t COMP_Z = 2'd3;

  // Operation selector carried in tuser
  typedef enum logic {
    OP_PRODUCT = 1'b0,
    OP_ROTATE  = 1'b1
  } opcode_t;

  // Hamilton product: result component c is the sum over t of
  // +/- left[HAM_A_IDX[c][t]] * right[HAM_B_IDX[c][t]], negated where HAM_NEG is set.
  localparam comp_idx_t HAM_A_IDX [NUM_COMP][NUM_TERMS] = '{
    '{COMP_W, COMP_X, COMP_Y, COMP_Z},
    '{COMP_W, COMP_X, COMP_Y, COMP_Z},
    '{COMP_W, COMP_Y, COMP_Z, COMP_X},
    '{COMP_W, COMP_Z, COMP_X, COMP_Y}
  };

  localparam comp_idx_t HAM_B_IDX [NUM_COMP][NUM_TERMS] = '{
    '{COMP_W, COMP_X, COMP_Y, COMP_Z},
    '{COMP_X, COMP_W, COMP_Z, COMP_Y},
    '{COMP_Y, COMP_W, COMP_X, COMP_Z},
    '{COMP_Z, COMP_W, COMP_Y, COMP_X}
  };

  localparam logic HAM_NEG [NUM_COMP][NUM_TERMS] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1}
  };

endpackage

`default_nettype wire

// ===== src/qmr_mul.sv =====
// Multiply stage: the sixteen partial products of a Hamilton product, registered.
`default_nettype none

module qmr_mul #(
  parameter int A_BITS    = qmr_pkg::COMPONENT_BITS_DEF,
  parameter int B_BITS    = qmr_pkg::COMPONENT_BITS_DEF,
  parameter int SIDE_BITS = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [qmr_pkg::NUM_COMP-1:0][A_BITS-1:0] a,
  input  logic [qmr_pkg::NUM_COMP-1:0][B_BITS-1:0] b,
  input  logic [SIDE_BITS-1:0] side_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [qmr_pkg::NUM_COMP-1:0][qmr_pkg::NUM_TERMS-1:0][A_BITS+B_BITS-1:0] prod,
  output logic [SIDE_BITS-1:0] side_out
);
  import qmr_pkg::*;

  localparam int PW = A_BITS + B_BITS;

  logic [NUM_COMP-1:0][NUM_TERMS-1:0][PW-1:0] prod_next;
  logic valid;

  // Signed products, operands extended to full product width first
  always_comb begin
    logic signed [PW-1:0] ax;
    logic signed [PW-1:0] bx;
    prod_next = '0;
    for (int c = 0; c < NUM_COMP; c++) begin
      for (int t = 0; t < NUM_TERMS; t++) begin
        ax = PW'($signed(a[HAM_A_IDX[c][t]]));
        bx = PW'($signed(b[HAM_B_IDX[c][t]]));
        prod_next[c][t] = PW'(ax * bx);
      end
    end
  end

  // Stage advances when empty or when downstream takes the request
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod     <= prod_next;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/qmr_rnd.sv =====
// Sum stage: adds four signed products, rounds to nearest and saturates each component.
`default_nettype none

module qmr_rnd #(
  parameter int PROD_BITS = 2 * qmr_pkg::COMPONENT_BITS_DEF,
  parameter int COMP_BITS = qmr_pkg::COMPONENT_BITS_DEF,
  parameter int SIDE_BITS = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [qmr_pkg::NUM_COMP-1:0][qmr_pkg::NUM_TERMS-1:0][PROD_BITS-1:0] prod,
  input  logic [SIDE_BITS-1:0] side_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [qmr_pkg::NUM_COMP-1:0][COMP_BITS-1:0] res,
  output logic [SIDE_BITS-1:0] side_out
);
  import qmr_pkg::*;

  // Two guard bits cover the four-term sum and the rounding constant
  localparam int SW   = PROD_BITS + 2;
  localparam int FRAC = COMP_BITS - 1;

  localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (FRAC - 1);
  localparam logic signed [SW-1:0] SAT_MAX  = {{(SW - COMP_BITS + 1){1'b0}},
                                               {(COMP_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN  = ~SAT_MAX;

  logic [NUM_COMP-1:0][COMP_BITS-1:0] res_next;
  logic valid;

  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] term;
    logic signed [SW-1:0] shifted;
    res_next = '0;
    for (int c = 0; c < NUM_COMP; c++) begin
      acc = RND_HALF;
      for (int t = 0; t < NUM_TERMS; t++) begin
        term = SW'($signed(prod[c][t]));
        acc  = HAM_NEG[c][t] ? acc - term : acc + term;
      end
      shifted = acc >>> FRAC;
      // Clamp to the signed component range
      if (shifted > SAT_MAX) begin
        res_next[c] = SAT_MAX[COMP_BITS-1:0];
      end else if (shifted < SAT_MIN) begin
        res_next[c] = SAT_MIN[COMP_BITS-1:0];
      end else begin
        res_next[c] = shifted[COMP_BITS-1:0];
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res      <= res_next;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/quaternion_multiply_rotate.sv =====
// Top level of the pipelined fixed-point quaternion product and vector rotation unit.
//
//  Channel   Direction  Ports                               Carries
//  s_*       in         s_tvalid s_tready s_tdata s_tuser   one operation request
//  m_*       out        m_tvalid m_tready m_tdata           one result request
//
// One request per cycle sustained while m_tready stays high.
// Four register stages: multiply a*b, sum/round, multiply by conj(a), sum/round.
// Product requests pass all stages; their a*b result rides on in the side band.
// Reset clears the stage valid bits and the in-flight count; no state links requests.
// Stalled full stages move on into free ones; s_tready drops only when all are full.
`default_nettype none

module quaternion_multiply_rotate #(
  parameter int COMPONENT_BITS = qmr_pkg::COMPONENT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (lowest first)
  input  logic [8*COMPONENT_BITS-1:0] s_tdata,
  // opcode
  input  logic [0:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // r_w, r_x, r_y, r_z (lowest first), zero padded to whole bytes
  output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_tdata
);
  import qmr_pkg::*;

  localparam int W        = COMPONENT_BITS;
  localparam int CW       = W + 1;
  localparam int SIDE     = 1 + NUM_COMP * W;
  localparam int OUT_BITS = ((4 * W + 7) / 8) * 8;

  opcode_t opcode;
  logic [NUM_COMP-1:0][W-1:0] a_in;
  logic [NUM_COMP-1:0][W-1:0] b_in;

  // Unpack request; rotation treats b as a pure vector
  always_comb begin
    opcode = opcode_t'(s_tuser[0]);
    for (int i = 0; i < NUM_COMP; i++) begin
      a_in[i] = s_tdata[i*W +: W];
      b_in[i] = s_tdata[(NUM_COMP + i)*W +: W];
    end
    if (opcode == OP_ROTATE) begin
      b_in[COMP_W] = '0;
    end
  end

  // First product a*b
  logic v1, r1, v2, r2, v3, r3, v4;
  logic [NUM_COMP-1:0][NUM_TERMS-1:0][2*W-1:0] prod1;
  logic [SIDE-1:0] side1, side2;

  qmr_mul #(.A_BITS(W), .B_BITS(W), .SIDE_BITS(SIDE)) u_mul1 (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .a(a_in), .b(b_in), .side_in({opcode, a_in}),
    .out_valid(v1), .out_ready(r1),
    .prod(prod1), .side_out(side1)
  );

  logic [NUM_COMP-1:0][W-1:0] q1;

  qmr_rnd #(.PROD_BITS(2*W), .COMP_BITS(W), .SIDE_BITS(SIDE)) u_rnd1 (
    .clk, .rst,
    .in_valid(v1), .in_ready(r1),
    .prod(prod1), .side_in(side1),
    .out_valid(v2), .out_ready(r2),
    .res(q1), .side_out(side2)
  );

  // Conjugate of a, one bit wider so the most negative code negates exactly
  logic [NUM_COMP-1:0][W-1:0]  a_held;
  logic [NUM_COMP-1:0][CW-1:0] a_conj;
  logic                        op2;

  always_comb begin
    a_held = side2[NUM_COMP*W-1:0];
    op2    = side2[SIDE-1];
    for (int i = 0; i < NUM_COMP; i++) begin
      if (i == COMP_W) begin
        a_conj[i] = CW'($signed(a_held[i]));
      end else begin
        a_conj[i] = CW'(-$signed(CW'($signed(a_held[i]))));
      end
    end
  end

  // Second product (a*v)*conj(a)
  logic [NUM_COMP-1:0][NUM_TERMS-1:0][W+CW-1:0] prod2;
  logic [SIDE-1:0] side3, side4;

  qmr_mul #(.A_BITS(W), .B_BITS(CW), .SIDE_BITS(SIDE)) u_mul2 (
    .clk, .rst,
    .in_valid(v2), .in_ready(r2),
    .a(q1), .b(a_conj), .side_in({op2, q1}),
    .out_valid(v3), .out_ready(r3),
    .prod(prod2), .side_out(side3)
  );

  logic [NUM_COMP-1:0][W-1:0] q2;

  qmr_rnd #(.PROD_BITS(W+CW), .COMP_BITS(W), .SIDE_BITS(SIDE)) u_rnd2 (
    .clk, .rst,
    .in_valid(v3), .in_ready(r3),
    .prod(prod2), .side_in(side3),
    .out_valid(v4), .out_ready(m_tready),
    .res(q2), .side_out(side4)
  );

  // Result select: rotate takes the second product, w zeroed; product takes the first
  logic [NUM_COMP-1:0][W-1:0] res;
  logic                       op4;

  always_comb begin
    op4 = side4[SIDE-1];
    if (opcode_t'(op4) == OP_ROTATE) begin
      res         = q2;
      res[COMP_W] = '0;
    end else begin
      res = side4[NUM_COMP*W-1:0];
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = OUT_BITS'(res);

  // Requests in flight, for checking stage occupancy
  logic [2:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
    end
  end

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    inflight == 3'($countones({v1, v2, v3, v4})))
    else $error("in-flight count does not match stage valid bits");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && !m_tready) |-> !s_tready)
    else $error("input accepted while pipeline full and stalled");

  a_free_accepts: assert property (@(posedge clk) disable iff (rst)
    (!(v1 && v2 && v3 && v4)) |-> s_tready)
    else $error("input refused while a stage is free");

  a_rot_w_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && op4) |-> (m_tdata[W-1:0] == '0))
    else $error("rotation result has nonzero scalar part");

endmodule

`default_nettype wire
